// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, with reset handling.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define AST_CHK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked during reset too
`define AST_CHK_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/icwu_pkg.sv
// ---------------------------------------------------------------------------
// icwu_pkg
// Widths, register map and constants of the congestion window update core.
// ---------------------------------------------------------------------------
package icwu_pkg;

   localparam int MAX_HOPS       = 8;
   localparam int UTIL_FRAC_BITS = 16;
   localparam int HOP_IDX_W      = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

   localparam int SEQ_W   = 48;
   localparam int RATE_W  = 39;
   localparam int QUEUE_W = 32;
   localparam int HOPS_W  = 4;
   localparam int UTIL_W  = 20;
   localparam int WIN_W   = 32;
   localparam int RTT_W   = 32;

   // stream payload widths
   localparam int REQ_DATA_W = 272;
   localparam int RSP_DATA_W = 56;

   // arithmetic unit widths
   localparam int ACC_W    = 108;
   localparam int DEN_W    = 87;
   localparam int MPLIER_W = 48;
   localparam int WPROD_W  = WIN_W + UTIL_W;
   localparam int QUO_W    = WPROD_W + 1;
   localparam int CNT_W    = 6;

   localparam logic [UTIL_W-1:0] UTIL_MAX = '1;
   localparam logic [WIN_W-1:0]  WIN_MAX  = '1;
   localparam logic [7:0]        STAGE_MAX = 8'hFF;
   localparam logic [HOPS_W-1:0] HOP_POS_MAX = '1;

   // 10^12 picoseconds per second, pre-scaled by 8 bits/byte and the Q format
   localparam logic [ACC_W-1:0] PS_PER_S_SCALED =
      ACC_W'(64'd1000000000000) << (3 + UTIL_FRAC_BITS);

   // configuration register map
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_BASE_RTT    = 3'd0;
   localparam logic [2:0] CSR_TARGET_UTIL = 3'd1;
   localparam logic [2:0] CSR_MAX_STAGES  = 3'd2;
   localparam logic [2:0] CSR_INCREASE    = 3'd3;
   localparam logic [2:0] CSR_INIT_WINDOW = 3'd4;

   localparam logic [31:0] RST_BASE_RTT    = 32'd12000000;
   localparam logic [15:0] RST_TARGET_UTIL = 16'd62259;
   localparam logic [7:0]  RST_MAX_STAGES  = 8'd5;
   localparam logic [15:0] RST_INCREASE    = 16'd1500;
   localparam logic [31:0] RST_INIT_WINDOW = 32'd15000;

   // target utilization in the Q4.F utilization format
   function automatic logic [UTIL_W-1:0] eta_of(input logic [15:0] target);
      logic [16+UTIL_FRAC_BITS-1:0] wide;
      wide = {target, {UTIL_FRAC_BITS{1'b0}}} >> 16;
      return UTIL_W'(wide);
   endfunction

endpackage

// File: rtl/int_congestion_window_update_core.sv
// ---------------------------------------------------------------------------
// int_congestion_window_update_core
// Sender-side congestion window computation from in-band hop telemetry.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one transfer per telemetry hop record of an ack, tlast on
//    the final record; tuser = 1 marks a NACK, which resets both windows to
//    the increase value and answers at once.
//  - rsp channel: one transfer per ack (on its last record) and per NACK,
//    carrying the new window, smoothed utilization and two flags.
//  - csr port: APB-style register writes and reads, pready tied high.
//  - Arithmetic: a bit-serial shift-add multiplier and a restoring
//    divider, one bit per cycle, do all the arithmetic. A compared hop uses
//    four products and two 21-step divisions; the last record adds smoothing
//    (two products, a division) and, on the multiplicative path, the window
//    product and division. A NACK or an uncompared middle record uses neither.
//  - req_tready is high only when idle; one item is worked on at a time.
//  - A result waits in the output register while rsp_tready is low; no new
//    item is taken until that transfer completes.
//  - Reset (synchronous) restores register defaults, clears the path and
//    sets the reference window to the initial window. Hop records are not cleared.
// ---------------------------------------------------------------------------
module int_congestion_window_update_core (
   input  logic                                clock,
   input  logic                                reset,
   // req: ack_number, send_next, hop_count, tx_bytes, hop_time, queue_len,
   //      link_rate (from bit 0 up), zero padded
   input  logic [icwu_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,  // cmd
   input  logic                                req_tlast,  // last_hop
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp: window_bytes, utilization (from bit 0 up), zero padded
   output logic [icwu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,  // path_reset, ref_updated
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // csr
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [icwu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_MUL, ST_DIV, ST_OUT} state_type;
   typedef enum logic [4:0] {
      PH_NACK, PH_CHECK, PH_D1, PH_N1, PH_DV1, PH_D2, PH_N2, PH_DV2,
      PH_HOPEND, PH_REC, PH_FIN, PH_SM2, PH_SMDIV, PH_SMEND, PH_WIN, PH_WDIV,
      PH_WEND
   } phase_type;

   localparam int AW = icwu_pkg::ACC_W;
   localparam int UW = icwu_pkg::UTIL_W;
   localparam int WW = icwu_pkg::WIN_W;
   localparam int SW = icwu_pkg::SEQ_W;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // configuration
   logic [31:0] base_rtt_ff, base_rtt_in;
   logic [15:0] target_ff, target_in;
   logic [7:0]  max_stages_ff, max_stages_in;
   logic [15:0] increase_ff, increase_in;
   logic [31:0] init_win_ff, init_win_in;

   // captured item
   logic                           cmd_ff, cmd_in, last_ff, last_in;
   logic [SW-1:0]                  ack_ff, ack_in, snd_ff, snd_in;
   logic [SW-1:0]                  tx_ff, tx_in, time_ff, time_in;
   logic [icwu_pkg::HOPS_W-1:0]    hops_ff, hops_in;
   logic [icwu_pkg::QUEUE_W-1:0]   queue_ff, queue_in;
   logic [icwu_pkg::RATE_W-1:0]    rate_ff, rate_in;

   // per-hop records
   logic [SW-1:0]                  prev_tx_ff   [icwu_pkg::MAX_HOPS];
   logic [SW-1:0]                  prev_time_ff [icwu_pkg::MAX_HOPS];
   logic [icwu_pkg::QUEUE_W-1:0]   prev_queue_ff[icwu_pkg::MAX_HOPS];
   logic                           rec_we;

   // path and window state
   logic [icwu_pkg::HOPS_W-1:0]    stored_hops_ff, stored_hops_in;
   logic [UW-1:0]                  smooth_ff, smooth_in;
   logic [WW-1:0]                  ref_win_ff, ref_win_in;
   logic [7:0]                     stage_ff, stage_in;
   logic [SW-1:0]                  last_seq_ff, last_seq_in;
   logic [UW-1:0]                  worst_ff, worst_in;
   logic [SW-1:0]                  worst_tau_ff, worst_tau_in;
   logic [icwu_pkg::HOPS_W-1:0]    hop_pos_ff, hop_pos_in;
   logic                           mismatch_ff, mismatch_in;

   // shared arithmetic unit
   logic [AW-1:0]                  acc_ff, acc_in, mcand_ff, mcand_in, dsh_ff, dsh_in;
   logic [icwu_pkg::MPLIER_W-1:0]  mplier_ff, mplier_in;
   logic [icwu_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [icwu_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [icwu_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [UW-1:0]                  t1_ff, t1_in;
   logic [31:0]                    tau_ff, tau_in;
   logic                           upd_ff, upd_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]                  rsp_win_ff, rsp_win_in;
   logic [UW-1:0]                  rsp_util_ff, rsp_util_in;
   logic                           rsp_reset_ff, rsp_reset_in, rsp_upd_ff, rsp_upd_in;

   // combinational helpers
   logic [icwu_pkg::HOP_IDX_W-1:0] idx;
   logic                           in_range, mism, csr_wr, mul_path;
   logic [SW-1:0]                  dtx, dt;
   logic [icwu_pkg::QUEUE_W-1:0]   qmin;
   logic [UW-1:0]                  eta, quo_sat, util_hop;
   logic [UW:0]                    util_sum;
   logic [31:0]                    tau_sel;
   logic [WW:0]                    w_add_sum;
   logic [icwu_pkg::QUO_W:0]       w_mul_sum;
   logic [WW-1:0]                  w_add, w_mul, w_fin;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(icwu_pkg::RSP_DATA_W - UW - WW){1'b0}}, rsp_util_ff, rsp_win_ff};
   assign rsp_tuser  = {rsp_upd_ff, rsp_reset_ff};

   // register read
   always_comb begin
      case (csr_paddr[4:2])
         icwu_pkg::CSR_BASE_RTT:    csr_prdata = base_rtt_ff;
         icwu_pkg::CSR_TARGET_UTIL: csr_prdata = {16'd0, target_ff};
         icwu_pkg::CSR_MAX_STAGES:  csr_prdata = {24'd0, max_stages_ff};
         icwu_pkg::CSR_INCREASE:    csr_prdata = {16'd0, increase_ff};
         icwu_pkg::CSR_INIT_WINDOW: csr_prdata = init_win_ff;
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // hop record lookup and derived values
   assign idx      = hop_pos_ff[icwu_pkg::HOP_IDX_W-1:0];
   assign in_range = ({1'b0, hop_pos_ff} < 5'(icwu_pkg::MAX_HOPS)) && (hop_pos_ff < hops_ff);
   assign dtx      = tx_ff - prev_tx_ff[idx];
   assign dt       = time_ff - prev_time_ff[idx];
   assign qmin     = (queue_ff < prev_queue_ff[idx]) ? queue_ff : prev_queue_ff[idx];
   assign mism     = mismatch_ff | (hops_ff != stored_hops_ff);
   assign eta      = icwu_pkg::eta_of(target_ff);

   // quotient saturated to the utilization range
   assign quo_sat  = quo_ff[UW] ? icwu_pkg::UTIL_MAX : quo_ff[UW-1:0];
   assign util_sum = {1'b0, t1_ff} + {1'b0, quo_sat};
   assign util_hop = util_sum[UW] ? icwu_pkg::UTIL_MAX : util_sum[UW-1:0];

   // smoothing interval: tau = min(worst dt, T), or T when the worst utilization is zero
   assign tau_sel  = (worst_ff == '0) ? base_rtt_ff :
                     (worst_tau_ff > SW'(base_rtt_ff)) ? base_rtt_ff : worst_tau_ff[31:0];

   // window candidates
   assign mul_path  = (smooth_ff >= eta) || (stage_ff >= max_stages_ff);
   assign w_add_sum = {1'b0, ref_win_ff} + (WW+1)'(increase_ff);
   assign w_add     = w_add_sum[WW] ? icwu_pkg::WIN_MAX : w_add_sum[WW-1:0];
   assign w_mul_sum = {1'b0, quo_ff} + (icwu_pkg::QUO_W+1)'(increase_ff);
   assign w_mul     = (w_mul_sum > (icwu_pkg::QUO_W+1)'(icwu_pkg::WIN_MAX)) ?
                      icwu_pkg::WIN_MAX : w_mul_sum[WW-1:0];
   assign w_fin     = (phase_ff == PH_WEND) ? w_mul : w_add;

   assign rec_we = (state_ff == ST_SETUP) && (phase_ff == PH_REC) && in_range;

   // sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      base_rtt_in    = base_rtt_ff;
      target_in      = target_ff;
      max_stages_in  = max_stages_ff;
      increase_in    = increase_ff;
      init_win_in    = init_win_ff;
      cmd_in         = cmd_ff;
      last_in        = last_ff;
      ack_in         = ack_ff;
      snd_in         = snd_ff;
      tx_in          = tx_ff;
      time_in        = time_ff;
      hops_in        = hops_ff;
      queue_in       = queue_ff;
      rate_in        = rate_ff;
      stored_hops_in = stored_hops_ff;
      smooth_in      = smooth_ff;
      ref_win_in     = ref_win_ff;
      stage_in       = stage_ff;
      last_seq_in    = last_seq_ff;
      worst_in       = worst_ff;
      worst_tau_in   = worst_tau_ff;
      hop_pos_in     = hop_pos_ff;
      mismatch_in    = mismatch_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      dsh_in         = dsh_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      den_in         = den_ff;
      t1_in          = t1_ff;
      tau_in         = tau_ff;
      upd_in         = upd_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_win_in     = rsp_win_ff;
      rsp_util_in    = rsp_util_ff;
      rsp_reset_in   = rsp_reset_ff;
      rsp_upd_in     = rsp_upd_ff;

      // register writes (only while idle, by the user; the block does not enforce it)
      if (csr_wr) begin
         case (csr_paddr[4:2])
            icwu_pkg::CSR_BASE_RTT:    base_rtt_in   = csr_pwdata;
            icwu_pkg::CSR_TARGET_UTIL: target_in     = csr_pwdata[15:0];
            icwu_pkg::CSR_MAX_STAGES:  max_stages_in = csr_pwdata[7:0];
            icwu_pkg::CSR_INCREASE:    increase_in   = csr_pwdata[15:0];
            icwu_pkg::CSR_INIT_WINDOW: init_win_in   = csr_pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               last_in  = req_tlast;
               ack_in   = req_tdata[47:0];
               snd_in   = req_tdata[95:48];
               hops_in  = req_tdata[99:96];
               tx_in    = req_tdata[147:100];
               time_in  = req_tdata[195:148];
               queue_in = req_tdata[227:196];
               rate_in  = req_tdata[266:228];
               phase_in = req_tuser ? PH_NACK : PH_CHECK;
               state_in = ST_SETUP;
            end
         end

         // shift-add multiply, one multiplier bit a cycle
         ST_MUL: begin
            if (mplier_ff == '0) begin
               state_in = ST_SETUP;
            end else begin
               if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end

         // restoring divide, one quotient bit a cycle (remainder in acc)
         ST_DIV: begin
            if (acc_ff >= dsh_ff) begin
               acc_in = acc_ff - dsh_ff;
               quo_in = {quo_ff[icwu_pkg::QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[icwu_pkg::QUO_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) state_in = ST_SETUP;
            else cnt_in = cnt_ff - 1'b1;
         end

         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_SETUP: begin
            case (phase_ff)
               PH_NACK: begin
                  ref_win_in   = WW'(increase_ff);
                  rsp_win_in   = WW'(increase_ff);
                  rsp_util_in  = smooth_ff;
                  rsp_reset_in = 1'b0;
                  rsp_upd_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  hop_pos_in   = '0;
                  worst_in     = '0;
                  worst_tau_in = SW'(base_rtt_ff);
                  mismatch_in  = 1'b0;
                  state_in     = ST_OUT;
               end
               PH_CHECK: begin
                  mismatch_in = mism;
                  phase_in    = (in_range && !mism) ? PH_D1 : PH_REC;
               end
               // queue term divisor: link_rate * T
               PH_D1: begin
                  acc_in    = '0;
                  mcand_in  = AW'(rate_ff);
                  mplier_in = icwu_pkg::MPLIER_W'(base_rtt_ff);
                  state_in  = ST_MUL;
                  phase_in  = PH_N1;
               end
               PH_N1: begin
                  den_in    = acc_ff[icwu_pkg::DEN_W-1:0];
                  acc_in    = '0;
                  mcand_in  = icwu_pkg::PS_PER_S_SCALED;
                  mplier_in = icwu_pkg::MPLIER_W'(qmin);
                  state_in  = ST_MUL;
                  phase_in  = PH_DV1;
               end
               PH_DV1: begin
                  dsh_in   = AW'(den_ff) << UW;
                  quo_in   = '0;
                  cnt_in   = icwu_pkg::CNT_W'(UW);
                  state_in = ST_DIV;
                  phase_in = PH_D2;
               end
               // rate term divisor: dt * link_rate
               PH_D2: begin
                  t1_in     = quo_sat;
                  acc_in    = '0;
                  mcand_in  = AW'(dt);
                  mplier_in = icwu_pkg::MPLIER_W'(rate_ff);
                  state_in  = ST_MUL;
                  phase_in  = PH_N2;
               end
               PH_N2: begin
                  den_in    = acc_ff[icwu_pkg::DEN_W-1:0];
                  acc_in    = '0;
                  mcand_in  = icwu_pkg::PS_PER_S_SCALED;
                  mplier_in = dtx;
                  state_in  = ST_MUL;
                  phase_in  = PH_DV2;
               end
               PH_DV2: begin
                  dsh_in   = AW'(den_ff) << UW;
                  quo_in   = '0;
                  cnt_in   = icwu_pkg::CNT_W'(UW);
                  state_in = ST_DIV;
                  phase_in = PH_HOPEND;
               end
               PH_HOPEND: begin
                  if (util_hop > worst_ff) begin
                     worst_in     = util_hop;
                     worst_tau_in = dt;
                  end
                  phase_in = PH_REC;
               end
               // records are written here; move on or close the ack
               PH_REC: begin
                  if (!last_ff) begin
                     if (hop_pos_ff != icwu_pkg::HOP_POS_MAX) hop_pos_in = hop_pos_ff + 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     phase_in = PH_FIN;
                  end
               end
               PH_FIN: begin
                  upd_in = ack_ff > last_seq_ff;
                  if (mismatch_ff) begin
                     stored_hops_in = hops_ff;
                     phase_in       = PH_WIN;
                  end else if (base_rtt_ff != '0) begin
                     tau_in    = tau_sel;
                     acc_in    = '0;
                     mcand_in  = AW'(base_rtt_ff - tau_sel);
                     mplier_in = icwu_pkg::MPLIER_W'(smooth_ff);
                     state_in  = ST_MUL;
                     phase_in  = PH_SM2;
                  end else begin
                     phase_in = PH_WIN;
                  end
               end
               // accumulate tau * worst onto (T - tau) * U
               PH_SM2: begin
                  mcand_in  = AW'(tau_ff);
                  mplier_in = icwu_pkg::MPLIER_W'(worst_ff);
                  state_in  = ST_MUL;
                  phase_in  = PH_SMDIV;
               end
               PH_SMDIV: begin
                  dsh_in   = AW'(base_rtt_ff) << UW;
                  quo_in   = '0;
                  cnt_in   = icwu_pkg::CNT_W'(UW);
                  state_in = ST_DIV;
                  phase_in = PH_SMEND;
               end
               PH_SMEND: begin
                  smooth_in = quo_ff[UW-1:0];
                  phase_in  = PH_WIN;
               end
               PH_WIN, PH_WEND: begin
                  if (phase_ff == PH_WIN && mul_path) begin
                     // multiplicative: ref * eta, then divide by U
                     acc_in    = '0;
                     mcand_in  = AW'(ref_win_ff);
                     mplier_in = icwu_pkg::MPLIER_W'(eta);
                     state_in  = ST_MUL;
                     phase_in  = PH_WDIV;
                  end else begin
                     if (upd_ff) begin
                        ref_win_in  = w_fin;
                        last_seq_in = snd_ff;
                        if (phase_ff == PH_WEND) stage_in = '0;
                        else if (stage_ff != icwu_pkg::STAGE_MAX) stage_in = stage_ff + 1'b1;
                     end
                     rsp_win_in   = w_fin;
                     rsp_util_in  = smooth_ff;
                     rsp_reset_in = mismatch_ff;
                     rsp_upd_in   = upd_ff;
                     rsp_valid_in = 1'b1;
                     hop_pos_in   = '0;
                     worst_in     = '0;
                     worst_tau_in = SW'(base_rtt_ff);
                     mismatch_in  = 1'b0;
                     state_in     = ST_OUT;
                  end
               end
               PH_WDIV: begin
                  dsh_in   = AW'(smooth_ff) << icwu_pkg::WPROD_W;
                  quo_in   = '0;
                  cnt_in   = icwu_pkg::CNT_W'(icwu_pkg::WPROD_W);
                  state_in = ST_DIV;
                  phase_in = PH_WEND;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_CHECK;
         base_rtt_ff    <= icwu_pkg::RST_BASE_RTT;
         target_ff      <= icwu_pkg::RST_TARGET_UTIL;
         max_stages_ff  <= icwu_pkg::RST_MAX_STAGES;
         increase_ff    <= icwu_pkg::RST_INCREASE;
         init_win_ff    <= icwu_pkg::RST_INIT_WINDOW;
         stored_hops_ff <= '0;
         smooth_ff      <= icwu_pkg::eta_of(icwu_pkg::RST_TARGET_UTIL);
         ref_win_ff     <= icwu_pkg::RST_INIT_WINDOW;
         stage_ff       <= '0;
         last_seq_ff    <= '0;
         worst_ff       <= '0;
         worst_tau_ff   <= SW'(icwu_pkg::RST_BASE_RTT);
         hop_pos_ff     <= '0;
         mismatch_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         base_rtt_ff    <= base_rtt_in;
         target_ff      <= target_in;
         max_stages_ff  <= max_stages_in;
         increase_ff    <= increase_in;
         init_win_ff    <= init_win_in;
         stored_hops_ff <= stored_hops_in;
         smooth_ff      <= smooth_in;
         ref_win_ff     <= ref_win_in;
         stage_ff       <= stage_in;
         last_seq_ff    <= last_seq_in;
         worst_ff       <= worst_in;
         worst_tau_ff   <= worst_tau_in;
         hop_pos_ff     <= hop_pos_in;
         mismatch_ff    <= mismatch_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      last_ff      <= last_in;
      ack_ff       <= ack_in;
      snd_ff       <= snd_in;
      tx_ff        <= tx_in;
      time_ff      <= time_in;
      hops_ff      <= hops_in;
      queue_ff     <= queue_in;
      rate_ff      <= rate_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      den_ff       <= den_in;
      t1_ff        <= t1_in;
      tau_ff       <= tau_in;
      upd_ff       <= upd_in;
      rsp_win_ff   <= rsp_win_in;
      rsp_util_ff  <= rsp_util_in;
      rsp_reset_ff <= rsp_reset_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

   // hop records, overwritten once the hop is evaluated
   always_ff @(posedge clock) begin
      if (rec_we) begin
         prev_tx_ff[idx]    <= tx_ff;
         prev_time_ff[idx]  <= time_ff;
         prev_queue_ff[idx] <= queue_ff;
      end
   end

endmodule

// File: rtl/icwu_checker.sv
// ---------------------------------------------------------------------------
// icwu_checker
// Port-level checks of the congestion window update core, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module icwu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic [icwu_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            req_tlast,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [icwu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            csr_pready
);

   // a waiting result keeps its payload
   `AST_CHK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed while stalled")

   // nothing is shown right after reset
   `AST_CHK_RST(a_rst_quiet, reset |=> !rsp_tvalid, "rsp valid after reset")

   // no new item taken while a result waits
   `AST_CHK(a_one_at_time, rsp_tvalid |-> !req_tready, "input taken while result pending")

   // a middle hop record of an ack gives no result
   `AST_CHK(a_mid_hop, req_tvalid && req_tready && !req_tuser && !req_tlast |=> !rsp_tvalid, "result after a non-final hop record")

   // register port never stalls
   `AST_CHK_RST(a_pready, csr_pready, "csr pready low")

endmodule

bind int_congestion_window_update_core icwu_checker u_icwu_checker (.*);

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the congestion window update core. Hop records are fed on
// the req stream under several register settings and idle patterns. Each
// accepted record runs through a local fixed-point model of the window
// update, and each rsp transfer is checked against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [127:0] PS_PER_SEC = 128'd1000000000000;

   typedef struct packed {
      logic        cmd;
      logic [47:0] ack_no;
      logic [47:0] snd_nxt;
      logic [3:0]  hops;
      logic [47:0] tx;
      logic [47:0] ts;
      logic [31:0] qlen;
      logic [38:0] rate;
      logic        last;
   } hop_rec_type;

   typedef struct packed {
      logic [31:0] window;
      logic [19:0] util;
      logic        path_reset;
      logic        ref_updated;
   } window_res_type;

   logic                            clock = 0;
   logic                            reset = 1;
   logic [icwu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 0;
   logic                            req_tlast = 0;
   logic                            req_tvalid = 0;
   logic                            req_tready;
   logic [icwu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 0;
   logic                            csr_psel = 0;
   logic                            csr_penable = 0;
   logic                            csr_pwrite = 0;
   logic [icwu_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   int_congestion_window_update_core uut (.*);

   always #5 clock = ~clock;

   // pending hop records and predicted window results
   hop_rec_type    rec_queue[$];
   window_res_type window_exp[$];
   int             send_idle = 0;
   int             rsp_stall = 0;
   int             err_count = 0;
   int             idle_cycles = 0;
   logic           req_hs = 0;

   // model copy of registers and state
   logic [31:0] cfg_rtt = icwu_pkg::RST_BASE_RTT;
   logic [15:0] cfg_target = icwu_pkg::RST_TARGET_UTIL;
   logic [7:0]  cfg_stages = icwu_pkg::RST_MAX_STAGES;
   logic [15:0] cfg_inc = icwu_pkg::RST_INCREASE;
   logic [31:0] cfg_init = icwu_pkg::RST_INIT_WINDOW;
   logic [47:0] seen_tx[icwu_pkg::MAX_HOPS];
   logic [47:0] seen_ts[icwu_pkg::MAX_HOPS];
   logic [31:0] seen_q[icwu_pkg::MAX_HOPS];
   logic [3:0]  path_hops = 0;
   logic [19:0] util_avg;
   logic [31:0] ref_win = icwu_pkg::RST_INIT_WINDOW;
   logic [31:0] cur_win = icwu_pkg::RST_INIT_WINDOW;
   logic [7:0]  stage_cnt = 0;
   logic [47:0] update_seq = 0;
   logic [19:0] worst_u = 0;
   logic [47:0] worst_dt = 48'(icwu_pkg::RST_BASE_RTT);
   logic [3:0]  rec_pos = 0;
   logic        path_changed = 0;

   // generator view of the path, so no unwritten hop record is ever compared
   logic [3:0]  gen_hops = 0;
   logic [7:0]  gen_written = 0;
   logic [47:0] gen_tx[icwu_pkg::MAX_HOPS];
   logic [47:0] gen_ts[icwu_pkg::MAX_HOPS];
   logic [47:0] gen_snd = 0;
   int          rec_total = 0;

   function automatic logic [19:0] eta_q(input logic [15:0] target);
      logic [63:0] v;
      v = (64'(target) << icwu_pkg::UTIL_FRAC_BITS) >> 16;
      return v[19:0];
   endfunction

   function automatic logic [19:0] util_quot(input logic [127:0] num, input logic [127:0] den);
      logic [127:0] q;
      if (den == 0) return icwu_pkg::UTIL_MAX;
      q = num / den;
      return (q > 128'(icwu_pkg::UTIL_MAX)) ? icwu_pkg::UTIL_MAX : q[19:0];
   endfunction

   function automatic void clear_ack_state();
      rec_pos = 0;
      worst_u = 0;
      worst_dt = 48'(cfg_rtt);
      path_changed = 0;
   endfunction

   // window update for one accepted hop record
   function automatic void predict_window(input hop_rec_type r);
      logic [19:0]    eta, u, t1, t2;
      logic [31:0]    qmin;
      logic [47:0]    dtx, dt, tau;
      logic [127:0]   w;
      logic           upd;
      window_res_type res;
      eta = eta_q(cfg_target);
      if (r.cmd) begin
         ref_win = 32'(cfg_inc);
         cur_win = 32'(cfg_inc);
         clear_ack_state();
         res = '{cur_win, util_avg, 1'b0, 1'b0};
         window_exp.push_back(res);
         return;
      end
      if (r.hops != path_hops) path_changed = 1;
      if (rec_pos < r.hops && rec_pos < icwu_pkg::MAX_HOPS) begin
         if (!path_changed) begin
            qmin = (r.qlen < seen_q[rec_pos]) ? r.qlen : seen_q[rec_pos];
            dtx = r.tx - seen_tx[rec_pos];
            dt = r.ts - seen_ts[rec_pos];
            t1 = util_quot((128'(qmin) * 8 * PS_PER_SEC) << icwu_pkg::UTIL_FRAC_BITS,
                           128'(r.rate) * 128'(cfg_rtt));
            t2 = util_quot((128'(dtx) * 8 * PS_PER_SEC) << icwu_pkg::UTIL_FRAC_BITS,
                           128'(dt) * 128'(r.rate));
            u = (21'(t1) + 21'(t2) > 21'(icwu_pkg::UTIL_MAX)) ? icwu_pkg::UTIL_MAX : t1 + t2;
            if (u > worst_u) begin
               worst_u = u;
               worst_dt = dt;
            end
         end
         seen_tx[rec_pos] = r.tx;
         seen_ts[rec_pos] = r.ts;
         seen_q[rec_pos] = r.qlen;
      end
      if (!r.last) begin
         if (rec_pos < icwu_pkg::HOP_POS_MAX) rec_pos++;
         return;
      end
      // smoothing, or reload of the path on a hop count change
      if (path_changed) begin
         path_hops = r.hops;
      end else if (cfg_rtt != 0) begin
         tau = (worst_u == 0) ? 48'(cfg_rtt) : worst_dt;
         if (tau > 48'(cfg_rtt)) tau = 48'(cfg_rtt);
         w = ((128'(cfg_rtt) - 128'(tau)) * 128'(util_avg) + 128'(tau) * 128'(worst_u))
             / 128'(cfg_rtt);
         util_avg = w[19:0];
      end
      upd = r.ack_no > update_seq;
      if (util_avg >= eta || stage_cnt >= cfg_stages) begin
         if (util_avg == 0) w = 128'(icwu_pkg::WIN_MAX);
         else w = 128'(ref_win) * 128'(eta) / 128'(util_avg) + 128'(cfg_inc);
         if (w > 128'(icwu_pkg::WIN_MAX)) w = 128'(icwu_pkg::WIN_MAX);
         if (upd) begin
            stage_cnt = 0;
            ref_win = w[31:0];
         end
      end else begin
         w = 128'(ref_win) + 128'(cfg_inc);
         if (w > 128'(icwu_pkg::WIN_MAX)) w = 128'(icwu_pkg::WIN_MAX);
         if (upd) begin
            if (stage_cnt < icwu_pkg::STAGE_MAX) stage_cnt++;
            ref_win = w[31:0];
         end
      end
      if (upd) update_seq = r.snd_nxt;
      cur_win = w[31:0];
      res = '{cur_win, util_avg, path_changed, upd};
      clear_ack_state();
      window_exp.push_back(res);
   endfunction

   // request driver: fields change on the falling edge
   always @(negedge clock) begin
      hop_rec_type r;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_hs) begin
         if (rec_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
            r = rec_queue.pop_front();
            req_tdata <= icwu_pkg::REQ_DATA_W'({r.rate, r.qlen, r.ts, r.tx, r.hops,
                                                r.snd_nxt, r.ack_no});
            req_tuser <= r.cmd;
            req_tlast <= r.last;
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_stall);
   end

   // monitor: model on each req transfer, compare each rsp transfer
   always @(posedge clock) begin
      hop_rec_type    r;
      window_res_type e;
      req_hs <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         r.cmd = req_tuser;
         r.last = req_tlast;
         {r.rate, r.qlen, r.ts, r.tx, r.hops, r.snd_nxt, r.ack_no} = req_tdata[266:0];
         predict_window(r);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (window_exp.size() == 0) begin
            $error("rsp transfer with no result expected");
            err_count++;
         end else begin
            e = window_exp.pop_front();
            if (rsp_tdata[31:0] !== e.window) begin
               $error("window_bytes: expected %0d, got %0d", e.window, rsp_tdata[31:0]);
               err_count++;
            end
            if (rsp_tdata[51:32] !== e.util) begin
               $error("utilization: expected %0d, got %0d", e.util, rsp_tdata[51:32]);
               err_count++;
            end
            if (rsp_tuser[0] !== e.path_reset) begin
               $error("path_reset: expected %0d, got %0d", e.path_reset, rsp_tuser[0]);
               err_count++;
            end
            if (rsp_tuser[1] !== e.ref_updated) begin
               $error("ref_updated: expected %0d, got %0d", e.ref_updated, rsp_tuser[1]);
               err_count++;
            end
         end
      end
      // watchdog on cycles with no transfer at all
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      case (idx)
         icwu_pkg::CSR_BASE_RTT:    cfg_rtt = val;
         icwu_pkg::CSR_TARGET_UTIL: cfg_target = val[15:0];
         icwu_pkg::CSR_MAX_STAGES:  cfg_stages = val[7:0];
         icwu_pkg::CSR_INCREASE:    cfg_inc = val[15:0];
         icwu_pkg::CSR_INIT_WINDOW: cfg_init = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] rtt, input logic [15:0] tgt,
                            input logic [7:0] stg, input logic [15:0] inc,
                            input logic [31:0] init);
      csr_write(icwu_pkg::CSR_BASE_RTT, rtt);
      csr_write(icwu_pkg::CSR_TARGET_UTIL, 32'(tgt));
      csr_write(icwu_pkg::CSR_MAX_STAGES, 32'(stg));
      csr_write(icwu_pkg::CSR_INCREASE, 32'(inc));
      csr_write(icwu_pkg::CSR_INIT_WINDOW, init);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // plausible record for hop position p; advances that hop's counters
   function automatic hop_rec_type plain_rec(input int p, input logic [3:0] n);
      hop_rec_type  r;
      logic [127:0] dt, dtx;
      logic [38:0]  rate;
      case ($urandom_range(4))
         0: rate = 39'd10000000000;
         1: rate = 39'd25000000000;
         2: rate = 39'd100000000000;
         3: rate = 39'd400000000000;
         default: rate = 39'($urandom_range(1000000, 32'hFFFFFFFF)) << $urandom_range(7);
      endcase
      if (rate == 0) rate = 1;
      dt = ($urandom_range(30) == 0) ? 0 : 128'($urandom_range(1000, 30000000));
      dtx = 128'(rate) * dt * 128'($urandom_range(130)) / (PS_PER_SEC * 800);
      gen_ts[p] = gen_ts[p] + 48'(dt);
      gen_tx[p] = gen_tx[p] + 48'(dtx);
      r.cmd = 0;
      r.ack_no = gen_snd - 48'($urandom_range(20000));
      r.snd_nxt = gen_snd;
      r.hops = n;
      r.tx = gen_tx[p];
      r.ts = gen_ts[p];
      r.qlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(300000);
      r.rate = rate;
      r.last = 0;
      return r;
   endfunction

   function automatic hop_rec_type noise_rec(input logic [3:0] n);
      hop_rec_type r;
      r.cmd = 0;
      r.ack_no = rand48();
      r.snd_nxt = rand48();
      r.hops = n;
      r.tx = rand48();
      r.ts = rand48();
      r.qlen = $urandom;
      r.rate = 39'({$urandom, $urandom});
      if (r.rate == 0) r.rate = 1;
      r.last = 0;
      return r;
   endfunction

   // walks an ack over the generator's path view; 0 if it would compare a
   // hop record that was never written
   function automatic bit walk_ack(ref hop_rec_type recs[$], input bit commit);
      logic [3:0] st, pos;
      logic [7:0] wr;
      bit         changed;
      st = gen_hops;
      wr = gen_written;
      pos = 0;
      changed = 0;
      foreach (recs[k]) begin
         if (recs[k].hops != st) changed = 1;
         if (pos < recs[k].hops && pos < icwu_pkg::MAX_HOPS) begin
            if (!changed && !wr[pos]) return 0;
            wr[pos] = 1;
         end
         if (recs[k].last) begin
            st = recs[k].hops;
            pos = 0;
            changed = 0;
         end else if (pos < icwu_pkg::HOP_POS_MAX) begin
            pos++;
         end
      end
      if (commit) begin
         gen_hops = st;
         gen_written = wr;
      end
      return 1;
   endfunction

   task automatic queue_ack(ref hop_rec_type recs[$], input bit then_nack);
      hop_rec_type nk;
      if (!walk_ack(recs, 0)) recs[0].hops = (gen_hops == 8) ? 4'd0 : 4'(gen_hops + 1);
      void'(walk_ack(recs, 1));
      foreach (recs[k]) rec_queue.push_back(recs[k]);
      rec_total += recs.size();
      if (then_nack) begin
         nk = noise_rec(gen_hops);
         nk.cmd = 1;
         nk.last = 1'($urandom_range(1));
         rec_queue.push_back(nk);
         rec_total++;
      end
   endtask

   // one ack: mostly well formed on a stable path, some noise and broken ones
   task automatic random_ack();
      hop_rec_type recs[$];
      logic [3:0]  n;
      int          cnt;
      bit          noisy, nack_after;
      gen_snd = gen_snd + 48'($urandom_range(0, 30000));
      noisy = ($urandom_range(99) < 20);
      nack_after = 0;
      if (!noisy) begin
         n = (gen_hops != 0 && $urandom_range(15) != 0) ? gen_hops : 4'($urandom_range(1, 8));
         cnt = (n == 0) ? 1 : n;
      end else begin
         n = 4'($urandom_range(8));
         cnt = ($urandom_range(9) == 0) ? 17 : $urandom_range(1, n + 2);
         nack_after = ($urandom_range(5) == 0);
      end
      for (int k = 0; k < cnt; k++) begin
         if (noisy && $urandom_range(2) == 0) recs.push_back(noise_rec(n));
         else recs.push_back(plain_rec(k % icwu_pkg::MAX_HOPS, n));
         if (noisy && $urandom_range(7) == 0) recs[k].hops = 4'($urandom_range(8));
      end
      if (!nack_after) recs[cnt-1].last = 1;
      queue_ack(recs, nack_after);
   endtask

   task automatic directed_acks();
      hop_rec_type recs[$];
      hop_rec_type nk;
      logic [47:0] prev_ts;
      nk = noise_rec(0);
      nk.cmd = 1;
      nk.last = 1;
      rec_queue.push_back(nk);
      // path setup, then a compared ack on two hops
      for (int a = 0; a < 2; a++) begin
         recs = {};
         gen_snd = gen_snd + 3000;
         recs.push_back(plain_rec(0, 2));
         recs.push_back(plain_rec(1, 2));
         recs[1].last = 1;
         queue_ack(recs, 0);
      end
      // zero time delta, counter wrap and field extremes
      recs = {};
      prev_ts = gen_ts[0];
      recs.push_back(plain_rec(0, 2));
      gen_ts[0] = prev_ts;
      recs[0].ts = prev_ts;
      recs[0].qlen = '1;
      recs.push_back(plain_rec(1, 2));
      recs[1].tx = 48'h0;
      recs[1].rate = '1;
      recs[1].ack_no = '1;
      recs[1].snd_nxt = '1;
      recs[1].last = 1;
      queue_ack(recs, 0);
      // no hops at all: path reload, then utilization falls to zero
      for (int a = 0; a < 2; a++) begin
         recs = {};
         recs.push_back(noise_rec(0));
         recs[0].last = 1;
         queue_ack(recs, 0);
      end
      // back to two hops, extra records past the hop count
      for (int a = 0; a < 2; a++) begin
         recs = {};
         for (int k = 0; k < 4; k++) recs.push_back(plain_rec(k % 2, 2));
         recs[3].last = 1;
         queue_ack(recs, 0);
      end
      // hop count changing inside an ack
      recs = {};
      recs.push_back(plain_rec(0, 2));
      recs.push_back(plain_rec(1, 3));
      recs[1].last = 1;
      queue_ack(recs, 0);
      // partial ack dropped by a nack
      recs = {};
      recs.push_back(plain_rec(0, 3));
      queue_ack(recs, 1);
   endtask

   task automatic wait_idle();
      while (rec_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (window_exp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int target;
      util_avg = eta_q(icwu_pkg::RST_TARGET_UTIL);
      for (int p = 0; p < icwu_pkg::MAX_HOPS; p++) begin
         gen_tx[p] = rand48();
         gen_ts[p] = rand48();
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: ;
            1: write_all(32'd1, 16'hFFFF, 8'd0, 16'hFFFF, 32'hFFFFFFFF);
            2: write_all(32'hFFFFFFFF, 16'd1, 8'd255, 16'd1, 32'd1);
            3: write_all(icwu_pkg::RST_BASE_RTT, icwu_pkg::RST_TARGET_UTIL, 8'd0,
                         icwu_pkg::RST_INCREASE, icwu_pkg::RST_INIT_WINDOW);
            default: write_all($urandom_range(1000000, 40000000),
                               16'($urandom_range(40000, 65535)),
                               8'($urandom_range(10)), 16'($urandom_range(500, 9000)),
                               $urandom);
         endcase
         case (ph % 4)
            0: begin send_idle = 0;  rsp_stall = 0;  end
            1: begin send_idle = 68; rsp_stall = 0;  end
            2: begin send_idle = 0;  rsp_stall = 68; end
            default: begin send_idle = 16; rsp_stall = 16; end
         endcase
         if (ph == 0) directed_acks();
         // two halves with a full drain in between
         for (int h = 0; h < 2; h++) begin
            target = rec_total + 97;
            while (rec_total < target) random_ack();
            while (rec_queue.size() != 0 || req_tvalid) @(posedge clock);
            while (window_exp.size() != 0) @(posedge clock);
         end
         wait_idle();
      end
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
